/* design/assert_macros.svh */
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* design/swsf_pkg.sv */
// Types, codes, constants and helper functions of the synth word snoop filter select.
`timescale 1ns / 1ps

package swsf_pkg;

    // Default depth of the op queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register addresses on the synthesizer SPI bus
    localparam logic [11:0] ADDR_DIV    = 12'h005;
    localparam logic [11:0] ADDR_RX_INT = 12'h231;
    localparam logic [11:0] ADDR_RX_F0  = 12'h233;
    localparam logic [11:0] ADDR_RX_F1  = 12'h234;
    localparam logic [11:0] ADDR_RX_F2  = 12'h235;
    localparam logic [11:0] ADDR_TX_INT = 12'h271;
    localparam logic [11:0] ADDR_TX_F0  = 12'h273;
    localparam logic [11:0] ADDR_TX_F1  = 12'h274;
    localparam logic [11:0] ADDR_TX_F2  = 12'h275;

    // Divider codes at or above this value leave the stored code alone
    localparam logic [3:0] DIV_CODE_LIMIT = 4'd7;

    // Fractional denominator and reference frequency in MHz
    localparam logic [23:0] FRAC_DEN = 24'd8388593;
    localparam logic [6:0]  REF_MHZ  = 7'd80;

    // Band bounds in Q14.10 MHz, ascending
    localparam int RX_NB = 6;
    localparam int TX_NB = 8;
    localparam logic [23:0] RX_BOUNDS [RX_NB] = '{
        24'd460800, 24'd716800, 24'd1228800, 24'd1843200, 24'd2406400, 24'd2662400
    };
    localparam logic [23:0] TX_BOUNDS [TX_NB] = '{
        24'd120525, 24'd182477, 24'd291124, 24'd464589,
        24'd741172, 24'd1182618, 24'd1886823, 24'd3010560
    };

    // Input beat
    typedef struct packed {
        logic        action;
        logic [23:0] spi_word;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [2:0]  rx_band;
        logic [6:0]  rx_select;
        logic [3:0]  tx_band;
        logic [8:0]  tx_select;
        logic [23:0] rx_freq;
        logic [23:0] tx_freq;
    } t_out;

    // Classified operation handed from front to back
    typedef enum logic [3:0] {
        OP_FRAME,
        OP_OTHER,
        OP_DIV,
        OP_RX_INT,
        OP_RX_F0,
        OP_RX_F1,
        OP_RX_F2,
        OP_TX_INT,
        OP_TX_F0,
        OP_TX_F1,
        OP_TX_F2
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
    } t_op;

    // floor(frac * 80 * 1024 / FRAC_DEN): estimate by >>23, fix with one compare.
    // FRAC_DEN = 2^23 - 15, so the remainder is low bits plus 15 * estimate.
    function automatic logic [16:0] frac_term(input logic [22:0] frac);
        logic [25:0] p5;
        logic [16:0] q0;
        logic [20:0] q15;
        logic [23:0] rem;
        p5   = {3'b000, frac} * 26'd5;
        q0   = p5[25:9];
        q15  = {4'b0000, q0} * 21'd15;
        rem  = {1'b0, p5[8:0], 14'b0} + {3'b000, q15};
        return q0 + {16'b0, (rem >= FRAC_DEN)};
    endfunction

    // Receive band: number of bounds at or below the frequency
    function automatic logic [2:0] rx_band_of(input logic [23:0] f);
        logic [2:0] b;
        b = '0;
        for (int k = 0; k < RX_NB; k++) begin
            if (f >= RX_BOUNDS[k]) begin
                b = 3'(k + 1);
            end
        end
        return b;
    endfunction

    // Transmit band
    function automatic logic [3:0] tx_band_of(input logic [23:0] f);
        logic [3:0] b;
        b = '0;
        for (int k = 0; k < TX_NB; k++) begin
            if (f >= TX_BOUNDS[k]) begin
                b = 4'(k + 1);
            end
        end
        return b;
    endfunction

endpackage

/* design/synth_word_snoop_filter_select.sv */
// Top level of the synthesizer SPI word snoop and filter band select.
`timescale 1ns / 1ps

// Snoops synthesizer SPI words and reports receive and transmit filter bands on
// each frame-end beat. A front stage registers and decodes each input beat, then
// a queue of Q_DEPTH ops decouples it from the back sequencer. In the back, a
// snooped word only updates the shadow registers until a divider word has been
// seen; from then on, that word included, it runs the steps shadow update,
// fractional quotient term, sum and shift, and no new op is taken until idle. A
// frame-end beat needs a free result register. Results come from a register, so
// words keep flowing while a result waits, until the next frame-end beat.

module synth_word_snoop_filter_select #(
    parameter int Q_DEPTH = swsf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  swsf_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output swsf_pkg::t_out o_out_data
);
    import swsf_pkg::*;

    logic f_valid, f_ready;
    t_op  f_op;
    logic q_valid, q_ready;
    t_op  q_op;

    swsf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_op_valid (f_valid),
        .i_op_ready (f_ready),
        .o_op       (f_op)
    );

    swsf_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_op    (f_op),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_op     (q_op)
    );

    swsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .o_op_ready  (q_ready),
        .i_op        (q_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* design/swsf_front.sv */
// Front stage: accepts input beats and classifies them into queue ops.
`timescale 1ns / 1ps

module swsf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  swsf_pkg::t_in  i_in_data,
    output logic           o_op_valid,
    input  logic           i_op_ready,
    output swsf_pkg::t_op  o_op
);
    import swsf_pkg::*;

    logic       r_valid;
    t_op        r_op;
    t_op        n_op;
    logic [11:0] addr;

    assign addr       = i_in_data.spi_word[19:8];
    assign o_in_ready = !r_valid || i_op_ready;
    assign o_op_valid = r_valid;
    assign o_op       = r_op;

    // Address decode
    always_comb begin
        n_op.data = i_in_data.spi_word[7:0];
        if (i_in_data.action) begin
            n_op.kind = OP_FRAME;
        end else begin
            unique case (addr)
                ADDR_DIV:    n_op.kind = OP_DIV;
                ADDR_RX_INT: n_op.kind = OP_RX_INT;
                ADDR_RX_F0:  n_op.kind = OP_RX_F0;
                ADDR_RX_F1:  n_op.kind = OP_RX_F1;
                ADDR_RX_F2:  n_op.kind = OP_RX_F2;
                ADDR_TX_INT: n_op.kind = OP_TX_INT;
                ADDR_TX_F0:  n_op.kind = OP_TX_F0;
                ADDR_TX_F1:  n_op.kind = OP_TX_F1;
                ADDR_TX_F2:  n_op.kind = OP_TX_F2;
                default:     n_op.kind = OP_OTHER;
            endcase
        end
    end

    // Staging register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_valid <= 1'b1;
        end else if (i_op_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op <= n_op;
        end
    end

endmodule

/* design/swsf_queue.sv */
// Small op queue between the front and back stages.
`timescale 1ns / 1ps

module swsf_queue #(
    parameter int DEPTH = swsf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  swsf_pkg::t_op  i_push_op,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output swsf_pkg::t_op  o_pop_op
);
    import swsf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_op          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_op     = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

/* design/swsf_back.sv */
// Back stage: shadow registers, frequency sequencer, band select and result register.
`timescale 1ns / 1ps

module swsf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    output logic           o_op_ready,
    input  swsf_pkg::t_op  i_op,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output swsf_pkg::t_out o_out_data
);
    import swsf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FRAC = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    logic [1:0]  r_state,   n_state;
    logic [7:0]  r_rx_int,  n_rx_int;
    logic [22:0] r_rx_frac, n_rx_frac;
    logic [7:0]  r_tx_int,  n_tx_int;
    logic [22:0] r_tx_frac, n_tx_frac;
    logic [2:0]  r_rx_code, n_rx_code;
    logic [2:0]  r_tx_code, n_tx_code;
    logic        r_seen,    n_seen;
    logic [23:0] r_rx_freq, n_rx_freq;
    logic [23:0] r_tx_freq, n_tx_freq;
    logic [16:0] r_rx_t,    n_rx_t;
    logic [16:0] r_tx_t,    n_tx_t;
    logic [14:0] r_rx_ip,   n_rx_ip;
    logic [14:0] r_tx_ip,   n_tx_ip;
    logic        r_out_valid, n_out_valid;
    t_out        r_out,     n_out;

    logic        pop;
    logic [7:0]  d;
    logic [2:0]  rb;
    logic [3:0]  tb;
    logic [14:0] rx_ip_sh, tx_ip_sh;
    logic [16:0] rx_t_sh,  tx_t_sh;
    logic [24:0] rx_sum,   tx_sum;

    // Frame end needs a free result slot; words only need the sequencer idle
    assign o_op_ready  = (r_state == ST_IDLE) &&
                         (i_op.kind != OP_FRAME || !r_out_valid || i_out_ready);
    assign pop         = i_op_valid && o_op_ready;
    assign d           = i_op.data;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Band lookup on the held frequencies
    assign rb = rx_band_of(r_rx_freq);
    assign tb = tx_band_of(r_tx_freq);

    // Divide by 2^(code+1) on both terms
    assign rx_ip_sh = (r_rx_ip >> 1) >> r_rx_code;
    assign tx_ip_sh = (r_tx_ip >> 1) >> r_tx_code;
    assign rx_t_sh  = (r_rx_t >> 1) >> r_rx_code;
    assign tx_t_sh  = (r_tx_t >> 1) >> r_tx_code;
    assign rx_sum   = {rx_ip_sh, 10'b0} + {8'b0, rx_t_sh};
    assign tx_sum   = {tx_ip_sh, 10'b0} + {8'b0, tx_t_sh};

    // Sequencer and shadow update
    always_comb begin
        n_state     = r_state;
        n_rx_int    = r_rx_int;
        n_rx_frac   = r_rx_frac;
        n_tx_int    = r_tx_int;
        n_tx_frac   = r_tx_frac;
        n_rx_code   = r_rx_code;
        n_tx_code   = r_tx_code;
        n_seen      = r_seen;
        n_rx_freq   = r_rx_freq;
        n_tx_freq   = r_tx_freq;
        n_rx_t      = r_rx_t;
        n_tx_t      = r_tx_t;
        n_rx_ip     = r_rx_ip;
        n_tx_ip     = r_tx_ip;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    unique case (i_op.kind)
                        OP_FRAME: begin
                            n_out_valid     = 1'b1;
                            n_out.rx_band   = rb;
                            n_out.rx_select = 7'd1 << rb;
                            n_out.tx_band   = tb;
                            n_out.tx_select = 9'd1 << tb;
                            n_out.rx_freq   = r_rx_freq;
                            n_out.tx_freq   = r_tx_freq;
                        end
                        OP_DIV: begin
                            if (d[3:0] < DIV_CODE_LIMIT) begin
                                n_rx_code = d[2:0];
                            end
                            if (d[7:4] < DIV_CODE_LIMIT) begin
                                n_tx_code = d[6:4];
                            end
                            n_seen = 1'b1;
                        end
                        OP_RX_INT: n_rx_int = d;
                        OP_RX_F0:  n_rx_frac[7:0] = d;
                        OP_RX_F1:  n_rx_frac[15:8] = d;
                        OP_RX_F2:  n_rx_frac[22:16] = d[6:0];
                        OP_TX_INT: n_tx_int = d;
                        OP_TX_F0:  n_tx_frac[7:0] = d;
                        OP_TX_F1:  n_tx_frac[15:8] = d;
                        OP_TX_F2:  n_tx_frac[22:16] = d[6:0];
                        default: begin
                            // unknown address: no shadow change
                        end
                    endcase
                    if (i_op.kind != OP_FRAME && n_seen) begin
                        n_state = ST_FRAC;
                    end
                end
            end
            ST_FRAC: begin
                // integer product and fractional quotient, before the divider shift
                n_rx_ip = {7'b0, r_rx_int} * {8'b0, REF_MHZ};
                n_tx_ip = {7'b0, r_tx_int} * {8'b0, REF_MHZ};
                n_rx_t  = frac_term(r_rx_frac);
                n_tx_t  = frac_term(r_tx_frac);
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_rx_freq = rx_sum[23:0];
                n_tx_freq = tx_sum[23:0];
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rx_int    <= '0;
            r_rx_frac   <= '0;
            r_tx_int    <= '0;
            r_tx_frac   <= '0;
            r_rx_code   <= '0;
            r_tx_code   <= '0;
            r_seen      <= 1'b0;
            r_rx_freq   <= '0;
            r_tx_freq   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rx_int    <= n_rx_int;
            r_rx_frac   <= n_rx_frac;
            r_tx_int    <= n_tx_int;
            r_tx_frac   <= n_tx_frac;
            r_rx_code   <= n_rx_code;
            r_tx_code   <= n_tx_code;
            r_seen      <= n_seen;
            r_rx_freq   <= n_rx_freq;
            r_tx_freq   <= n_tx_freq;
            r_out_valid <= n_out_valid;
        end
    end

    // Intermediate terms and result payload
    always_ff @(posedge i_clk) begin
        r_rx_t  <= n_rx_t;
        r_tx_t  <= n_tx_t;
        r_rx_ip <= n_rx_ip;
        r_tx_ip <= n_tx_ip;
        r_out   <= n_out;
    end

endmodule

/* design/swsf_checker.sv */
// Port-level checker for the snoop filter select, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swsf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input swsf_pkg::t_out o_out_data
);
    import swsf_pkg::*;

    // A stalled result beat holds
    `ASSERT_CLK(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)), "result beat changed while stalled")

    // Selects agree with band indexes
    `ASSERT_IMPL(a_rx_sel, o_out_valid, o_out_data.rx_select == (7'd1 << o_out_data.rx_band), "rx select does not match band")
    `ASSERT_IMPL(a_tx_sel, o_out_valid, o_out_data.tx_select == (9'd1 << o_out_data.tx_band), "tx select does not match band")

    // Lowest receive band below the first bound
    `ASSERT_IMPL(a_rx_low, o_out_valid && (o_out_data.rx_freq < RX_BOUNDS[0]), o_out_data.rx_band == 3'd0, "rx band wrong below first bound")

endmodule

bind synth_word_snoop_filter_select swsf_checker u_swsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
